@@ hdl/tkn_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkn_pkg
// Shared types, character codes and keyword tables for the expression
// tokeniser.
// ----------------------------------------------------------------------------
package tkn_pkg;

    // Default saturation limit for the token length.
    localparam int MAX_TOKEN_LEN_DEF = 255;

    // Character codes.
    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_DOT   = 8'h2E; // '.'
    localparam logic [7:0] CHR_SEMI  = 8'h3B; // ';'
    localparam logic [7:0] CHR_EQ    = 8'h3D; // '='
    localparam logic [7:0] CHR_GT    = 8'h3E; // '>'
    localparam logic [7:0] CHR_LT    = 8'h3C; // '<'
    localparam logic [7:0] CHR_BANG  = 8'h21; // '!'
    localparam logic [7:0] CHR_AMP   = 8'h26; // '&'
    localparam logic [7:0] CHR_PIPE  = 8'h7C; // '|'
    localparam logic [7:0] CHR_PLUS  = 8'h2B; // '+'
    localparam logic [7:0] CHR_MINUS = 8'h2D; // '-'
    localparam logic [7:0] CHR_STAR  = 8'h2A; // '*'
    localparam logic [7:0] CHR_SLASH = 8'h2F; // '/'
    localparam logic [7:0] CHR_PCT   = 8'h25; // '%'

    // Token kind codes.
    localparam logic [2:0] KIND_IDENT   = 3'd0;
    localparam logic [2:0] KIND_KEYWORD = 3'd1;
    localparam logic [2:0] KIND_NUMBER  = 3'd2;
    localparam logic [2:0] KIND_OPER    = 3'd3;
    localparam logic [2:0] KIND_SEMI    = 3'd4;

    // Keyword identifiers.
    localparam logic [1:0] KW_INT    = 2'd0;
    localparam logic [1:0] KW_RETURN = 2'd1;
    localparam logic [1:0] KW_IF     = 2'd2;
    localparam logic [1:0] KW_ELSE   = 2'd3;

    localparam int KW_COUNT   = 4;
    localparam int KW_MAX_LEN = 6;

    // Keyword spellings, indexed by keyword identifier then character place.
    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
        '{8'h69, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00},  // int
        '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6E},  // return
        '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},  // if
        '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00}   // else
    };
    localparam logic [7:0] KW_LEN [KW_COUNT] = '{8'd3, 8'd6, 8'd2, 8'd4};

    // Scanner mode.
    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_IDENT  = 2'd1,
        MODE_NUMBER = 2'd2,
        MODE_OPER   = 2'd3
    } t_scan_mode;

    // Scanner state carried from one byte to the next.
    typedef struct packed {
        t_scan_mode  mode;
        logic [15:0] start;
        logic [7:0]  run;
        logic [3:0]  mask;
        logic [7:0]  held;
        logic [15:0] pos;
    } t_scan_state;

    localparam t_scan_state SCAN_RESET = '{
        mode:  MODE_IDLE,
        start: 16'd0,
        run:   8'd0,
        mask:  4'hF,
        held:  8'd0,
        pos:   16'd0
    };

    // One reported token.
    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  kwid;
        logic [7:0]  op_first;
        logic [7:0]  op_second;
        logic [15:0] start;
        logic [7:0]  length;
    } t_token;

    // The tokens caused by one input byte.
    typedef struct packed {
        logic [1:0] count;
        t_token     first;
        t_token     second;
    } t_step_result;

    function automatic logic is_letter(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_operator(logic [7:0] c);
        return c == CHR_EQ || c == CHR_GT || c == CHR_LT || c == CHR_BANG ||
               c == CHR_AMP || c == CHR_PIPE || c == CHR_PLUS ||
               c == CHR_MINUS || c == CHR_STAR || c == CHR_SLASH ||
               c == CHR_PCT;
    endfunction

    function automatic logic pairs_with(logic [7:0] first, logic [7:0] second);
        return ((first == CHR_GT || first == CHR_LT || first == CHR_BANG) &&
                second == CHR_EQ) ||
               (first == CHR_AMP && second == CHR_AMP) ||
               (first == CHR_PIPE && second == CHR_PIPE);
    endfunction

    // Keeps those keyword candidates whose character at place k equals c.
    function automatic logic [3:0] narrow_mask(logic [3:0] mask, logic [7:0] k,
                                               logic [7:0] c);
        logic [3:0] res;
        res = '0;
        for (int b = 0; b < KW_COUNT; b++) begin
            if (mask[b] && (k < KW_LEN[b])) begin
                if (KW_TEXT[b][k[2:0]] == c) begin
                    res[b] = 1'b1;
                end
            end
        end
        return res;
    endfunction

endpackage

@@ hdl/tkn_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkn_if
// Valid/ready channels of the tokeniser: text bytes in, tokens out.
// ----------------------------------------------------------------------------
interface tkn_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface tkn_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [1:0]  keyword_id;
    logic [7:0]  op_first;
    logic [7:0]  op_second;
    logic [15:0] token_start;
    logic [7:0]  token_length;
    logic        last_of_run;

    modport source (output valid, output token_kind, output keyword_id,
                    output op_first, output op_second, output token_start,
                    output token_length, output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input keyword_id,
                    input op_first, input op_second, input token_start,
                    input token_length, input last_of_run, output ready);
endinterface

@@ hdl/tkn_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkn_step
// Classifies one text byte against the scanner state and gives the next
// state together with the zero, one or two tokens that the byte closes.
// ----------------------------------------------------------------------------
module tkn_step
    import tkn_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
    input  t_scan_state  i_state,
    input  logic [7:0]   i_char,
    output t_scan_state  o_state,
    output t_step_result o_result
);

    logic [7:0] w_run_grown;
    logic       w_close_vld;
    t_token     w_close_tok;
    t_token     w_pair_tok;
    t_token     w_semi_tok;
    logic [3:0] w_kw_hit;
    logic       w_emit_close;
    logic       w_emit_pair;
    logic       w_emit_semi;
    logic       w_consumed;

    // Saturating growth of the open run length.
    assign w_run_grown = (i_state.run < 8'(MAX_TOKEN_LEN)) ?
                         i_state.run + 8'd1 : i_state.run;

    // Keywords that still match and have exactly the run's length.
    always_comb begin
        for (int b = 0; b < KW_COUNT; b++) begin
            w_kw_hit[b] = i_state.mask[b] && (KW_LEN[b] == i_state.run);
        end
    end

    // The token that the open run would give if it closed now.
    always_comb begin
        w_close_tok       = '0;
        w_close_tok.start = i_state.start;
        w_close_vld       = 1'b0;
        unique case (i_state.mode)
            MODE_IDENT: begin
                w_close_vld        = 1'b1;
                w_close_tok.kind   = (w_kw_hit != '0) ? KIND_KEYWORD : KIND_IDENT;
                w_close_tok.length = i_state.run;
                for (int b = 0; b < KW_COUNT; b++) begin
                    if (w_kw_hit[b]) begin
                        w_close_tok.kwid = 2'(b);
                    end
                end
            end
            MODE_NUMBER: begin
                w_close_vld        = 1'b1;
                w_close_tok.kind   = KIND_NUMBER;
                w_close_tok.length = i_state.run;
            end
            MODE_OPER: begin
                w_close_vld          = 1'b1;
                w_close_tok.kind     = KIND_OPER;
                w_close_tok.op_first = i_state.held;
                w_close_tok.length   = 8'd1;
            end
            default: begin
                w_close_vld = 1'b0;
            end
        endcase
    end

    // Two-character operator and semicolon tokens.
    always_comb begin
        w_pair_tok           = '0;
        w_pair_tok.kind      = KIND_OPER;
        w_pair_tok.op_first  = i_state.held;
        w_pair_tok.op_second = i_char;
        w_pair_tok.start     = i_state.start;
        w_pair_tok.length    = 8'd2;

        w_semi_tok        = '0;
        w_semi_tok.kind   = KIND_SEMI;
        w_semi_tok.start  = i_state.pos;
        w_semi_tok.length = 8'd1;
    end

    // Next state and the choice of tokens to report.
    always_comb begin
        o_state      = i_state;
        w_emit_close = 1'b0;
        w_emit_pair  = 1'b0;
        w_emit_semi  = 1'b0;
        w_consumed   = 1'b0;

        if (i_char == CHR_NUL) begin
            // End of text: flush the open token and start over.
            w_emit_close = w_close_vld;
            o_state      = SCAN_RESET;
        end else begin
            unique case (i_state.mode)
                MODE_OPER: begin
                    if (pairs_with(i_state.held, i_char)) begin
                        w_emit_pair  = 1'b1;
                        w_consumed   = 1'b1;
                        o_state.mode = MODE_IDLE;
                        o_state.held = 8'd0;
                        o_state.run  = 8'd0;
                    end else begin
                        w_emit_close = 1'b1;
                    end
                end
                MODE_IDENT: begin
                    if (is_letter(i_char)) begin
                        w_consumed   = 1'b1;
                        o_state.mask = narrow_mask(i_state.mask, i_state.run, i_char);
                        o_state.run  = w_run_grown;
                    end else begin
                        w_emit_close = 1'b1;
                    end
                end
                MODE_NUMBER: begin
                    if (is_digit(i_char) || i_char == CHR_DOT) begin
                        w_consumed  = 1'b1;
                        o_state.run = w_run_grown;
                    end else begin
                        w_emit_close = 1'b1;
                    end
                end
                default: begin
                    w_consumed = 1'b0;
                end
            endcase

            // A byte not taken by the open run is classified afresh.
            if (!w_consumed) begin
                o_state.mode = MODE_IDLE;
                o_state.run  = 8'd0;
                o_state.mask = 4'hF;
                o_state.held = 8'd0;
                if (is_letter(i_char)) begin
                    o_state.mode  = MODE_IDENT;
                    o_state.start = i_state.pos;
                    o_state.run   = 8'd1;
                    o_state.mask  = narrow_mask(4'hF, 8'd0, i_char);
                end else if (is_digit(i_char)) begin
                    o_state.mode  = MODE_NUMBER;
                    o_state.start = i_state.pos;
                    o_state.run   = 8'd1;
                end else if (is_operator(i_char)) begin
                    o_state.mode  = MODE_OPER;
                    o_state.start = i_state.pos;
                    o_state.run   = 8'd1;
                    o_state.held  = i_char;
                end else if (i_char == CHR_SEMI) begin
                    w_emit_semi = 1'b1;
                end
            end

            o_state.pos = i_state.pos + 16'd1;
        end
    end

    // Order the reported tokens: a closed token always comes first.
    always_comb begin
        o_result = '0;
        if (w_emit_pair) begin
            o_result.count = 2'd1;
            o_result.first = w_pair_tok;
        end else if (w_emit_close && w_emit_semi) begin
            o_result.count  = 2'd2;
            o_result.first  = w_close_tok;
            o_result.second = w_semi_tok;
        end else if (w_emit_close) begin
            o_result.count = 2'd1;
            o_result.first = w_close_tok;
        end else if (w_emit_semi) begin
            o_result.count = 2'd1;
            o_result.first = w_semi_tok;
        end
    end

endmodule

@@ hdl/tkn_out_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkn_out_queue
// Two-record result queue. Each record holds the one or two tokens of a
// single input byte; the output side hands them out one transaction at a
// time and flags the last token of each record.
// ----------------------------------------------------------------------------
module tkn_out_queue
    import tkn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_step_result     i_result,
    output logic             o_can_push,
    tkn_out_if.source        o_out
);

    t_step_result r_rec [2];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic         r_sub;
    logic [1:0]   r_count;
    logic         n_sub;
    logic [1:0]   n_count;

    t_step_result w_head;
    t_token       w_tok;
    logic         w_last;
    logic         w_pop_tok;
    logic         w_pop_rec;

    // Head record and the token within it that is on offer.
    assign w_head    = r_rec[r_rd_ptr];
    assign w_tok     = r_sub ? w_head.second : w_head.first;
    assign w_last    = (w_head.count != 2'd2) || r_sub;
    assign w_pop_tok = o_out.valid && o_out.ready;
    assign w_pop_rec = w_pop_tok && w_last;

    assign o_can_push = (r_count != 2'd2);

    // Output payload.
    assign o_out.valid        = (r_count != 2'd0);
    assign o_out.token_kind   = w_tok.kind;
    assign o_out.keyword_id   = w_tok.kwid;
    assign o_out.op_first     = w_tok.op_first;
    assign o_out.op_second    = w_tok.op_second;
    assign o_out.token_start  = w_tok.start;
    assign o_out.token_length = w_tok.length;
    assign o_out.last_of_run  = w_last;

    // Occupancy and position within the head record.
    always_comb begin
        n_count = r_count + {1'b0, i_push} - {1'b0, w_pop_rec};
        n_sub   = r_sub;
        if (w_pop_rec) begin
            n_sub = 1'b0;
        end else if (w_pop_tok) begin
            n_sub = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 2'd0;
            r_sub    <= 1'b0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            r_count <= n_count;
            r_sub   <= n_sub;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop_rec) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    // Record storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_rec[r_wr_ptr] <= i_result;
        end
    end

    // The queue never holds more than two records.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("result queue occupancy beyond two records");

    // A record is never written while the queue is full.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != 2'd2))
        else $error("result record pushed into a full queue");

    // Taking the first of two tokens leaves the second on offer.
    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop_tok && !w_last) |=> (o_out.valid && r_sub))
        else $error("second token of a record not presented");

endmodule

@@ hdl/expression_tokenizer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expression_tokenizer_core
// Streaming lexical analyser: one text byte per transaction in, one token
// per transaction out (identifiers, keywords, numbers, operators and
// semicolons).
//
//   Channel | Dir | Payload                                        | Per transaction
//   --------+-----+------------------------------------------------+----------------
//   i_in    | in  | char_code                                      | one text byte
//   o_out   | out | token_kind, keyword_id, op_first, op_second,   | one token
//           |     | token_start, token_length, last_of_run         |
//
// A byte is classified in the cycle it is accepted; its tokens are registered in the
// result queue and offered on o_out after any earlier records there.
// One byte is taken every cycle while each byte gives at most one token and o_out
// is ready; a byte that gives two tokens occupies the output for two transactions.
// i_in.ready is low only while the two-record result queue is full, which
// happens when o_out stalls or when bytes that give two tokens arrive close
// together.
// Reset is synchronous and returns the scanner and the queue to empty.
// ----------------------------------------------------------------------------
module expression_tokenizer_core
    import tkn_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tkn_in_if.sink      i_in,
    tkn_out_if.source   o_out
);

    t_scan_state  r_state;
    t_scan_state  n_state;
    t_step_result w_result;
    logic         w_can_push;
    logic         w_accept;

    assign i_in.ready = w_can_push;
    assign w_accept   = i_in.valid && w_can_push;

    // Byte classification.
    tkn_step #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_step (
        .i_state  (r_state),
        .i_char   (i_in.char_code),
        .o_state  (n_state),
        .o_result (w_result)
    );

    // Scanner state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SCAN_RESET;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    // Result queue.
    tkn_out_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_accept && (w_result.count != 2'd0)),
        .i_result   (w_result),
        .o_can_push (w_can_push),
        .o_out      (o_out)
    );

    // A NUL byte returns the scanner to its starting position.
    a_nul_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.char_code == CHR_NUL) |=>
            (r_state.mode == MODE_IDLE && r_state.pos == 16'd0))
        else $error("scanner not restarted after NUL");

    // With no token open there is no run length and no held operator.
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode == MODE_IDLE) |-> (r_state.run == 8'd0 && r_state.held == 8'd0))
        else $error("idle scanner holds stale token state");

endmodule
